/* hdl/kbt_pkg.sv */
package kbt_pkg;

  localparam int SLOT_COUNT_DEF = 64;

  localparam logic [31:0] ALL_ONES  = 32'hffff_ffff;
  localparam logic [31:0] HIGH_HALF = 32'hffff_0000;
  localparam logic [31:0] LOW_HALF  = 32'h0000_ffff;
  localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;

  localparam logic [5:0] OP_SET      = 6'd0;
  localparam logic [5:0] OP_LD16C    = 6'd1;
  localparam logic [5:0] OP_SEXT16   = 6'd2;
  localparam logic [5:0] OP_LD32C    = 6'd3;
  localparam logic [5:0] OP_LD32S    = 6'd4;
  localparam logic [5:0] OP_ST32S    = 6'd5;
  localparam logic [5:0] OP_LD16S    = 6'd6;
  localparam logic [5:0] OP_STS      = 6'd7;
  localparam logic [5:0] OP_ADD      = 6'd8;
  localparam logic [5:0] OP_SUB      = 6'd9;
  localparam logic [5:0] OP_ADDI     = 6'd10;
  localparam logic [5:0] OP_DISCARD  = 6'd11;
  localparam logic [5:0] OP_XOR      = 6'd12;
  localparam logic [5:0] OP_XORI     = 6'd13;
  localparam logic [5:0] OP_MOV      = 6'd14;
  localparam logic [5:0] OP_AND      = 6'd15;
  localparam logic [5:0] OP_ANDI     = 6'd16;
  localparam logic [5:0] OP_OR       = 6'd17;
  localparam logic [5:0] OP_ORI      = 6'd18;
  localparam logic [5:0] OP_BOOL     = 6'd19;
  localparam logic [5:0] OP_NOT      = 6'd20;
  localparam logic [5:0] OP_SHLL     = 6'd21;
  localparam logic [5:0] OP_SHAR     = 6'd22;
  localparam logic [5:0] OP_SHLR     = 6'd23;
  localparam logic [5:0] OP_GTU      = 6'd24;
  localparam logic [5:0] OP_GTS      = 6'd25;
  localparam logic [5:0] OP_GTSI     = 6'd26;
  localparam logic [5:0] OP_EQ       = 6'd27;
  localparam logic [5:0] OP_GEU      = 6'd28;
  localparam logic [5:0] OP_GES      = 6'd29;
  localparam logic [5:0] OP_GESI     = 6'd30;
  localparam logic [5:0] OP_MUL      = 6'd31;
  localparam logic [5:0] OP_BARRIER  = 6'd32;

  typedef struct packed {
    logic [5:0]  op;
    logic        same_sd;
    logic [31:0] dm;
    logic [31:0] dv;
    logic [31:0] sm;
    logic [31:0] sv;
    logic [31:0] rm;
    logic [31:0] rv;
    logic [31:0] imm;
    logic [5:0]  sh;
  } kbt_opnd_t;

  typedef struct packed {
    logic [31:0] mask;
    logic [31:0] value;
  } kbt_know_t;

endpackage

/* hdl/kbt_alu.sv */
module kbt_alu import kbt_pkg::*; (
  input  kbt_opnd_t opnd,
  output kbt_know_t result
);

  logic [31:0] dm, dv, zb, ob, addend, sum, cmp_a, cmp_b, flip, shl_fill;
  logic [4:0]  sha;
  logic        sfull, rfull, dfull, gt, eq, decided, truth, cin;

  assign sfull = (opnd.sm == ALL_ONES);
  assign rfull = (opnd.rm == ALL_ONES);
  assign dfull = (opnd.dm == ALL_ONES);

  // shared adder: add, sub and add const
  always_comb begin
    cin    = 1'b0;
    addend = opnd.sv;
    if (opnd.op == OP_SUB) begin
      addend = ~opnd.sv;
      cin    = 1'b1;
    end else if (opnd.op == OP_ADDI) begin
      addend = opnd.imm;
    end
    sum = opnd.dv + addend + {31'd0, cin};
  end

  // shared comparator; signed forms compare with the sign bit flipped
  always_comb begin
    flip = 32'd0;
    if (opnd.op == OP_GTS || opnd.op == OP_GTSI || opnd.op == OP_GES || opnd.op == OP_GESI)
      flip = SIGN_BIT;
    cmp_a = opnd.sv ^ flip;
    cmp_b = ((opnd.op == OP_GTSI || opnd.op == OP_GESI) ? opnd.imm : opnd.rv) ^ flip;
    gt = (cmp_a > cmp_b);
    eq = (cmp_a == cmp_b);
    decided = (opnd.op == OP_GTSI || opnd.op == OP_GESI) ? sfull : (sfull && rfull);
    case (opnd.op)
      OP_GTU, OP_GTS, OP_GTSI: truth = gt;
      OP_EQ:                   truth = eq;
      default:                 truth = gt || eq;
    endcase
  end

  assign sha      = opnd.sh[4:0];
  assign shl_fill = ~(ALL_ONES << sha);

  always_comb begin
    dm = opnd.dm;
    dv = opnd.dv;
    zb = 32'd0;
    ob = 32'd0;
    case (opnd.op) inside
      OP_SET: begin
        dm = ALL_ONES;
        dv = opnd.imm;
      end
      OP_LD16C, OP_LD16S: begin
        dm = HIGH_HALF;
        dv = 32'd0;
      end
      OP_SEXT16: begin
        if (opnd.dm[15]) begin
          dm = opnd.dm | HIGH_HALF;
          dv = (opnd.dv & LOW_HALF) | (opnd.dv[15] ? HIGH_HALF : 32'd0);
        end else begin
          dm = opnd.dm & LOW_HALF;
          dv = opnd.dv & LOW_HALF;
        end
      end
      OP_LD32C, OP_LD32S, OP_DISCARD, OP_MUL: begin
        dm = 32'd0;
        dv = 32'd0;
      end
      OP_ST32S, OP_STS: begin
        dm = opnd.dm;
        dv = opnd.dv;
      end
      OP_ADD: begin
        if (sfull && dfull) begin
          dv = sum;
        end else if (opnd.same_sd) begin
          dv = opnd.dv << 1;
          dm = (opnd.dm << 1) | 32'd1;
        end else begin
          dm = 32'd0;
          dv = 32'd0;
        end
      end
      OP_SUB: begin
        if (sfull && dfull) begin
          dv = sum;
        end else if (opnd.same_sd) begin
          dm = ALL_ONES;
          dv = 32'd0;
        end else begin
          dm = 32'd0;
          dv = 32'd0;
        end
      end
      OP_ADDI: begin
        if (dfull) begin
          dv = sum;
        end else begin
          dm = 32'd0;
          dv = 32'd0;
        end
      end
      OP_XOR: begin
        if (opnd.same_sd) begin
          dm = ALL_ONES;
          dv = 32'd0;
        end else begin
          dm = opnd.dm & opnd.sm;
          dv = opnd.dv ^ opnd.sv;
        end
      end
      OP_XORI: dv = opnd.dv ^ opnd.imm;
      OP_MOV: begin
        dm = opnd.sm;
        dv = opnd.sv;
      end
      OP_AND: begin
        zb = (~opnd.sv & opnd.sm) | (~opnd.dv & opnd.dm);
        ob = (opnd.sv & opnd.sm) & (opnd.dv & opnd.dm);
        dm = zb | ob;
        dv = ob;
      end
      OP_ANDI: begin
        zb = ~opnd.imm | (~opnd.dv & opnd.dm);
        ob = opnd.imm & opnd.dv & opnd.dm;
        dm = zb | ob;
        dv = ob;
      end
      OP_OR: begin
        zb = (~opnd.sv & opnd.sm) & (~opnd.dv & opnd.dm);
        ob = (opnd.sv & opnd.sm) | (opnd.dv & opnd.dm);
        dm = zb | ob;
        dv = ob;
      end
      OP_ORI: begin
        zb = ~opnd.imm & (~opnd.dv & opnd.dm);
        ob = opnd.imm | (opnd.dv & opnd.dm);
        dm = zb | ob;
        dv = ob;
      end
      OP_BOOL: begin
        if (|(opnd.dv & opnd.dm)) begin
          dm = ALL_ONES;
          dv = 32'd1;
        end else if (dfull) begin
          dv = 32'd0;
        end else begin
          dm = ALL_ONES & ~32'd1;
          dv = 32'd0;
        end
      end
      OP_NOT: dv = ~opnd.dv;
      OP_SHLL: begin
        if (opnd.sh[5]) begin
          dm = ALL_ONES;
          dv = 32'd0;
        end else begin
          dv = opnd.dv << sha;
          dm = (opnd.dm << sha) | shl_fill;
        end
      end
      OP_SHAR: begin
        // distances past 31 act as 31
        dv = $unsigned($signed(opnd.dv) >>> (opnd.sh[5] ? 5'd31 : sha));
        dm = $unsigned($signed(opnd.dm) >>> (opnd.sh[5] ? 5'd31 : sha));
      end
      OP_SHLR: begin
        if (opnd.sh[5]) begin
          dm = ALL_ONES;
          dv = 32'd0;
        end else begin
          dv = opnd.dv >> sha;
          dm = (opnd.dm >> sha) | ~(ALL_ONES >> sha);
        end
      end
      OP_GTU, OP_GTS, OP_GTSI, OP_EQ, OP_GEU, OP_GES, OP_GESI: begin
        dm = decided ? ALL_ONES : (ALL_ONES & ~32'd1);
        dv = {31'd0, decided && truth};
      end
      default: begin
        dm = 32'd0;
        dv = 32'd0;
      end
    endcase
    result.mask  = dm;
    result.value = dv & dm;
  end

endmodule

/* hdl/known_bits_tracker_core.sv */
// Known-bits tracker for a stream of translator instructions.
// Request channel: valid/stall with block_start, opcode, dest_slot, source_slot,
// right_slot, immediate and shift_amount. Result channel: result_valid/
// result_stall with slot_out, known_mask, known_value and all_forgotten.
// One result per request, in order.
// Throughput: one request per cycle while stall is low. A request accepted
// into the read register moves to the result register once the result side
// is not stalled. The three slot reads come from registered RAM ports at the
// accept edge; the update logic sits between the read and result registers,
// with a forward path for the slot written at the accept edge.
// Slot knowledge lives in two RAM copies (one for dest/source, one for the
// right slot) plus a known flag per slot in flops. Reset clears the flags at
// once, so every slot reads as unknown right away; no clearing pass.
// A block start or an opcode >= 32 (barrier) clears all but the dest flag.
// When result_stall holds, the result register holds and the stage behind
// it fills; stall rises only when both are occupied.
module known_bits_tracker_core import kbt_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        stall,
  input  logic        block_start,
  input  logic [5:0]  opcode,
  input  logic [5:0]  dest_slot,
  input  logic [5:0]  source_slot,
  input  logic [5:0]  right_slot,
  input  logic [31:0] immediate,
  input  logic [5:0]  shift_amount,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [5:0]  slot_out,
  output logic [31:0] known_mask,
  output logic [31:0] known_value,
  output logic        all_forgotten
);

  localparam int IDX_W = $clog2(SLOT_COUNT);

  logic [5:0] wrap_lut [64];

  for (genvar g = 0; g < 64; g++) begin : g_wrap
    assign wrap_lut[g] = 6'(g % SLOT_COUNT);
  end

  kbt_know_t mem_a [SLOT_COUNT];
  kbt_know_t mem_b [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_known;
  logic [SLOT_COUNT-1:0] slot_known_next;

  logic        accept, s1_adv, s1_forgot;
  logic [5:0]  d_in, s_in, r_in;

  logic        s1_valid, s1_blk;
  logic [5:0]  s1_op, s1_d, s1_s, s1_r, s1_sh;
  logic [31:0] s1_imm;
  kbt_know_t   rd_d, rd_s, rd_r;
  logic        kn_d, kn_s, kn_r;

  logic        byp_wr, byp_forget;
  logic [5:0]  byp_addr;
  kbt_know_t   byp_know;

  kbt_know_t   op_d, op_s, op_r, alu_out;
  kbt_opnd_t   opnd;

  function automatic kbt_know_t pick(input logic [5:0] a, input kbt_know_t ram,
                                     input logic known, input logic blk,
                                     input logic bwr, input logic [5:0] baddr,
                                     input kbt_know_t bknow, input logic bfgt);
    kbt_know_t k;
    k = '0;
    if (blk)
      k = '0;
    else if (bwr && a == baddr)
      k = bknow;
    else if (!bfgt && known)
      k = ram;
    return k;
  endfunction

  assign d_in = wrap_lut[dest_slot];
  assign s_in = wrap_lut[source_slot];
  assign r_in = wrap_lut[right_slot];

  assign s1_adv = s1_valid && (!result_valid || !result_stall);
  assign stall  = s1_valid && !s1_adv;
  assign accept = valid && !stall;

  assign s1_forgot = s1_blk || s1_op[5];

  // read at accept, write at advance; read-before-write, forward covers it
  always_ff @(posedge clk) begin
    if (s1_adv)
      mem_a[IDX_W'(s1_d)] <= alu_out;
    if (accept) begin
      rd_d <= mem_a[IDX_W'(d_in)];
      rd_s <= mem_a[IDX_W'(s_in)];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv)
      mem_b[IDX_W'(s1_d)] <= alu_out;
    if (accept)
      rd_r <= mem_b[IDX_W'(r_in)];
  end

  always_comb begin
    slot_known_next = s1_forgot ? '0 : slot_known;
    slot_known_next[IDX_W'(s1_d)] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_known <= '0;
    end else if (s1_adv) begin
      slot_known <= slot_known_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_blk     <= block_start;
      s1_op      <= opcode;
      s1_d       <= d_in;
      s1_s       <= s_in;
      s1_r       <= r_in;
      s1_imm     <= immediate;
      s1_sh      <= shift_amount;
      kn_d       <= slot_known[IDX_W'(d_in)];
      kn_s       <= slot_known[IDX_W'(s_in)];
      kn_r       <= slot_known[IDX_W'(r_in)];
      byp_wr     <= s1_adv;
      byp_addr   <= s1_d;
      byp_know   <= alu_out;
      byp_forget <= s1_adv && s1_forgot;
    end
  end

  always_comb begin
    op_d = pick(s1_d, rd_d, kn_d, s1_blk, byp_wr, byp_addr, byp_know, byp_forget);
    op_s = pick(s1_s, rd_s, kn_s, s1_blk, byp_wr, byp_addr, byp_know, byp_forget);
    op_r = pick(s1_r, rd_r, kn_r, s1_blk, byp_wr, byp_addr, byp_know, byp_forget);
    opnd.op      = s1_op;
    opnd.same_sd = (s1_s == s1_d);
    opnd.dm      = op_d.mask;
    opnd.dv      = op_d.value;
    opnd.sm      = op_s.mask;
    opnd.sv      = op_s.value;
    opnd.rm      = op_r.mask;
    opnd.rv      = op_r.value;
    opnd.imm     = s1_imm;
    opnd.sh      = s1_sh;
  end

  kbt_alu u_alu (
    .opnd   (opnd),
    .result (alu_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      slot_out      <= s1_d;
      known_mask    <= alu_out.mask;
      known_value   <= alu_out.value;
      all_forgotten <= s1_forgot;
    end
  end

endmodule

/* hdl/kbt_checker.sv */
module kbt_checker import kbt_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [5:0]  slot_out,
  input logic [31:0] known_mask,
  input logic [31:0] known_value,
  input logic        all_forgotten
);

  // held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(slot_out) &&
      $stable(known_mask) && $stable(known_value) && $stable(all_forgotten))
    else $error("stalled result changed");

  // unknown bits always report zero
  a_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (known_value & ~known_mask) == 32'd0)
    else $error("value bit set outside known mask");

  // with an empty result register the request side never stalls
  a_nostall: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !stall)
    else $error("stall with empty result register");

  // an accepted request moves into the result register at the next edge
  // unless the result side is holding
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (valid && !stall) ##1 !result_stall |=> result_valid)
    else $error("result missing after accepted request");

endmodule

bind known_bits_tracker_core kbt_checker u_kbt_checker (.*);
